// ===== src/nrgold_pkg.sv =====
package nrgold_pkg;

  localparam int LFSR_W       = 31;
  localparam int WARMUP_STEPS = 1600;
  localparam int MAX_LENGTH   = 2048;
  localparam int IDX_W        = 8;
  localparam int LEN_W        = 12;
  localparam int SKIP_W       = 20;
  localparam int WORD_W       = 32;
  localparam int BIT_IDX_W    = 5;
  localparam int CNT_W        = 6;
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 40;
  localparam int SKIP_CHUNK   = 8;

  typedef logic [LFSR_W-1:0] lfsr_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_SKIP = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  // x1(n+31) = x1(n+3) ^ x1(n)
  function automatic lfsr_t adv_first(input lfsr_t x);
    logic fb;
    fb = x[0] ^ x[3];
    return {fb, x[LFSR_W-1:1]};
  endfunction

  // x2(n+31) = x2(n+3) ^ x2(n+2) ^ x2(n+1) ^ x2(n)
  function automatic lfsr_t adv_second(input lfsr_t x);
    logic fb;
    fb = x[0] ^ x[1] ^ x[2] ^ x[3];
    return {fb, x[LFSR_W-1:1]};
  endfunction

endpackage

// ===== src/nr_gold_sequence_generator_unit.sv =====
// operation: the offset product is formed first, then both registers are stepped over
// S = 1600 + block_index * seq_length positions, then one output bit is emitted per cycle
// unless a full word waits for the output register; a new request is taken only when the
// sequencer is back in idle, at once for a zero length request; the single lfsr stepping unit
// does 8 steps a cycle while 8 or more remain to skip, else 1, and 1 per bit while emitting
// reset: asynchronous active low, clears the seed to zero and returns the sequencer to idle
module nr_gold_sequence_generator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: c_init seed of the second register
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [7:0] block_index, [19:8] seq_length, [23:20] zero
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] sequence_bits, [37:32] bit_count, [39:38] zero
  output logic        m_axis_tlast_o    // last_word
);

  // sequencer state
  nrgold_pkg::state_e state_q, state_d;

  // seed register, first register seed is the constant 1
  nrgold_pkg::lfsr_t c_init_q;

  // working copies of both shift registers
  nrgold_pkg::lfsr_t x1_q, x1_d;
  nrgold_pkg::lfsr_t x2_q, x2_d;

  // request fields and counters
  logic [nrgold_pkg::IDX_W-1:0]     idx_q, idx_d;
  logic [nrgold_pkg::LEN_W-1:0]     rem_q, rem_d;     // bits still to emit
  logic [nrgold_pkg::SKIP_W-1:0]    skip_q, skip_d;   // steps still to skip
  logic [nrgold_pkg::BIT_IDX_W-1:0] bidx_q, bidx_d;   // bit position in current word
  logic [nrgold_pkg::WORD_W-1:0]    word_q, word_d;   // word being assembled

  // output register
  logic                             out_valid_q, out_valid_d;
  logic [nrgold_pkg::WORD_W-1:0]    out_bits_q, out_bits_d;
  logic [nrgold_pkg::CNT_W-1:0]     out_cnt_q, out_cnt_d;
  logic                             out_last_q, out_last_d;

  logic                             in_xfer;
  logic [nrgold_pkg::LEN_W-1:0]     len_in;
  logic [nrgold_pkg::LEN_W-1:0]     len_sat;
  logic [nrgold_pkg::SKIP_W-1:0]    product;
  logic                             word_done;
  logic                             out_free;
  logic                             cbit;
  nrgold_pkg::lfsr_t                x1_skip, x2_skip;

  assign s_axis_tready_o = (state_q == nrgold_pkg::S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // overlong requests saturate to the maximum length
  assign len_in  = s_axis_tdata_i[19:8];
  assign len_sat = (len_in > nrgold_pkg::LEN_W'(nrgold_pkg::MAX_LENGTH))
                 ? nrgold_pkg::LEN_W'(nrgold_pkg::MAX_LENGTH) : len_in;

  // skip offset product, 8 x 12 bits
  assign product = {{(nrgold_pkg::SKIP_W-nrgold_pkg::IDX_W){1'b0}}, idx_q}
                 * {{(nrgold_pkg::SKIP_W-nrgold_pkg::LEN_W){1'b0}}, rem_q};

  // eight chained steps for the skip phase
  always_comb begin
    x1_skip = x1_q;
    x2_skip = x2_q;
    for (int k = 0; k < nrgold_pkg::SKIP_CHUNK; k++) begin
      x1_skip = nrgold_pkg::adv_first(x1_skip);
      x2_skip = nrgold_pkg::adv_second(x2_skip);
    end
  end

  assign cbit      = x1_q[0] ^ x2_q[0];
  assign word_done = (bidx_q == '1) || (rem_q == nrgold_pkg::LEN_W'(1));
  // the output register can take a new word this cycle
  assign out_free  = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d     = state_q;
    x1_d        = x1_q;
    x2_d        = x2_q;
    idx_d       = idx_q;
    rem_d       = rem_q;
    skip_d      = skip_q;
    bidx_d      = bidx_q;
    word_d      = word_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_bits_d  = out_bits_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;

    case (state_q)
      nrgold_pkg::S_IDLE: begin
        if (in_xfer) begin
          idx_d   = s_axis_tdata_i[7:0];
          rem_d   = len_sat;
          x1_d    = nrgold_pkg::LFSR_W'(1);
          x2_d    = c_init_q;
          state_d = nrgold_pkg::S_MUL;
        end
      end
      nrgold_pkg::S_MUL: begin
        skip_d  = nrgold_pkg::SKIP_W'(nrgold_pkg::WARMUP_STEPS) + product;
        bidx_d  = '0;
        word_d  = '0;
        // a zero length request produces nothing
        state_d = (rem_q == '0) ? nrgold_pkg::S_IDLE : nrgold_pkg::S_SKIP;
      end
      nrgold_pkg::S_SKIP: begin
        if (skip_q >= nrgold_pkg::SKIP_W'(nrgold_pkg::SKIP_CHUNK)) begin
          x1_d   = x1_skip;
          x2_d   = x2_skip;
          skip_d = skip_q - nrgold_pkg::SKIP_W'(nrgold_pkg::SKIP_CHUNK);
        end else if (skip_q != '0) begin
          x1_d   = nrgold_pkg::adv_first(x1_q);
          x2_d   = nrgold_pkg::adv_second(x2_q);
          skip_d = skip_q - nrgold_pkg::SKIP_W'(1);
        end else begin
          state_d = nrgold_pkg::S_EMIT;
        end
      end
      nrgold_pkg::S_EMIT: begin
        // stall on a full or final word while the previous one is still waiting
        if (!word_done || out_free) begin
          x1_d   = nrgold_pkg::adv_first(x1_q);
          x2_d   = nrgold_pkg::adv_second(x2_q);
          rem_d  = rem_q - nrgold_pkg::LEN_W'(1);
          bidx_d = bidx_q + nrgold_pkg::BIT_IDX_W'(1);
          word_d = word_q | (nrgold_pkg::WORD_W'(cbit) << bidx_q);
          if (word_done) begin
            out_valid_d = 1'b1;
            out_bits_d  = word_q | (nrgold_pkg::WORD_W'(cbit) << bidx_q);
            out_cnt_d   = {1'b0, bidx_q} + nrgold_pkg::CNT_W'(1);
            out_last_d  = (rem_q == nrgold_pkg::LEN_W'(1));
            word_d      = '0;
            bidx_d      = '0;
            if (rem_q == nrgold_pkg::LEN_W'(1)) begin
              state_d = nrgold_pkg::S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = nrgold_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nrgold_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      c_init_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        c_init_q <= cfg_wdata_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    x1_q       <= x1_d;
    x2_q       <= x2_d;
    idx_q      <= idx_d;
    rem_q      <= rem_d;
    skip_q     <= skip_d;
    bidx_q     <= bidx_d;
    word_q     <= word_d;
    out_bits_q <= out_bits_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_cnt_q, out_bits_q};
  assign m_axis_tlast_o  = out_last_q;

  // a word never carries zero or more than 32 bits
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_cnt_q != '0) && (out_cnt_q <= nrgold_pkg::CNT_W'(32)))
    else $error("bit count out of range");

  // emission never runs with nothing left to emit
  a_emit_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nrgold_pkg::S_EMIT) |-> (rem_q != '0))
    else $error("emit state with zero remaining bits");

  // an accepted request goes to the offset product next
  a_accept_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == nrgold_pkg::S_MUL))
    else $error("request accepted without starting");

  // a short word is always the last word of its request
  a_short_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_cnt_q != nrgold_pkg::CNT_W'(32))) |-> m_axis_tlast_o)
    else $error("partial word not marked last");

endmodule

// ===== dv/nr_gold_sequence_generator_unit_tb.sv =====
`timescale 1ns / 100ps

module nr_gold_sequence_generator_unit_tb;

  // cycles to let pass after the last word before touching the seed or ending:
  // a trailing zero-length request leaves no word to wait for but still keeps the
  // block busy for a while
  localparam int SETTLE_CYCLES = 300;

  // one output word as it travels on the result stream
  typedef struct packed {
    logic                          last;
    logic [nrgold_pkg::CNT_W-1:0]  count;
    logic [nrgold_pkg::WORD_W-1:0] bits;
  } gold_word_t;

  logic                               clk_i           = 1'b0;
  logic                               rst_ni          = 1'b0;
  logic                               cfg_we_i        = 1'b0;
  logic [nrgold_pkg::LFSR_W-1:0]      cfg_wdata_i     = '0;
  logic                               s_axis_tvalid_i = 1'b0;
  logic                               s_axis_tready_o;
  logic [nrgold_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                               m_axis_tvalid_o;
  logic                               m_axis_tready_i = 1'b0;
  logic [nrgold_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                               m_axis_tlast_o;

  // seed of the second register as the block should hold it
  nrgold_pkg::lfsr_t seed_model = '0;
  gold_word_t        expected_words[$];
  gold_word_t        oldest_word;
  int unsigned       mismatch_count = 0;
  int unsigned       send_idle_pct  = 0;
  int unsigned       recv_stall_pct = 0;

  nr_gold_sequence_generator_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run both registers from their seeds over the skip, then collect the
  // gold bits 32 to a word, earliest bit in bit 0
  function automatic void predict_gold_words(
      input logic [nrgold_pkg::IDX_W-1:0] block_index,
      input logic [nrgold_pkg::LEN_W-1:0] seq_length);
    nrgold_pkg::lfsr_t x1;
    nrgold_pkg::lfsr_t x2;
    int unsigned       eff_len;
    int unsigned       skip;
    int unsigned       pos;
    gold_word_t        w;
    x1      = nrgold_pkg::lfsr_t'(1);
    x2      = seed_model;
    w       = '0;
    // overlong requests are cut to the maximum, for the skip as well
    eff_len = (seq_length > nrgold_pkg::MAX_LENGTH) ? nrgold_pkg::MAX_LENGTH : seq_length;
    // at most 1600 + 255 * 2048, well inside the 20-bit offset
    skip    = nrgold_pkg::WARMUP_STEPS + block_index * eff_len;
    for (int unsigned n = 0; n < skip + eff_len; n++) begin
      if (n >= skip) begin
        pos = n - skip;
        w.bits[pos % nrgold_pkg::WORD_W] = x1[0] ^ x2[0];
        w.count++;
        if (w.count == nrgold_pkg::WORD_W || pos == eff_len - 1) begin
          w.last = (pos == eff_len - 1);
          expected_words.push_back(w);
          w = '0;
        end
      end
      x1 = {x1[0] ^ x1[3], x1[nrgold_pkg::LFSR_W-1:1]};
      x2 = {x2[0] ^ x2[1] ^ x2[2] ^ x2[3], x2[nrgold_pkg::LFSR_W-1:1]};
    end
  endfunction

  function automatic void report_mismatch(input string what,
                                          input logic [nrgold_pkg::WORD_W-1:0] want,
                                          input logic [nrgold_pkg::WORD_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, what, want, got);
  endfunction

  // result side: check every transfer against the oldest expected word,
  // then pick the ready level for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", '0, m_axis_tdata_o[nrgold_pkg::WORD_W-1:0]);
      end else begin
        oldest_word = expected_words.pop_front();
        if (m_axis_tdata_o[nrgold_pkg::WORD_W-1:0] !== oldest_word.bits)
          report_mismatch("sequence_bits", oldest_word.bits,
                          m_axis_tdata_o[nrgold_pkg::WORD_W-1:0]);
        if (m_axis_tdata_o[nrgold_pkg::WORD_W +: nrgold_pkg::CNT_W] !== oldest_word.count)
          report_mismatch("bit_count", nrgold_pkg::WORD_W'(oldest_word.count),
                          nrgold_pkg::WORD_W'(
                            m_axis_tdata_o[nrgold_pkg::WORD_W +: nrgold_pkg::CNT_W]));
        if (m_axis_tlast_o !== oldest_word.last)
          report_mismatch("last_word", nrgold_pkg::WORD_W'(oldest_word.last),
                          nrgold_pkg::WORD_W'(m_axis_tlast_o));
      end
    end
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one request transfer; valid stays high afterwards so that back-to-back
  // requests never see a low and a high in the same step
  task automatic send_request(input logic [nrgold_pkg::IDX_W-1:0] block_index,
                              input logic [nrgold_pkg::LEN_W-1:0] seq_length);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    predict_gold_words(block_index, seq_length);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0, seq_length, block_index};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic idle_sender();
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (expected_words.size() != 0);
  endtask

  // the seed only changes with the block idle
  task automatic load_seed(input nrgold_pkg::lfsr_t seed);
    idle_sender();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= seed;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    seed_model   = seed;
  endtask

  // reset seed of zero: the output is the first register's sequence alone
  task automatic test_reset_seed();
    send_request(8'd0, 12'd1);
    send_request(8'd0, 12'd32);
    send_request(8'd0, 12'd33);
    send_request(8'd255, 12'd1);
  endtask

  // extremes of both fields, zero length and overlong requests
  task automatic test_field_extremes();
    load_seed(nrgold_pkg::lfsr_t'('1));
    send_request(8'd0, 12'd1);
    send_request(8'd0, 12'd31);
    send_request(8'd0, 12'd64);
    send_request(8'd1, 12'd100);
    send_request(8'd255, 12'd1);
    send_request(8'd128, 12'd7);
    // zero length: accepted, no words
    send_request(8'd0, 12'd0);
    send_request(8'd255, 12'd0);
    send_request(8'd3, 12'd2047);
    send_request(8'd255, 12'd2048);
    // overlong: cut to the maximum for the offset and the output
    send_request(8'd1, 12'd4095);
    send_request(8'd0, 12'd2049);
    send_request(8'd2, 12'd5);
  endtask

  // random requests over four idling phases, each with its own seed
  task automatic test_random_traffic();
    int unsigned                  send_pcts[4];
    int unsigned                  recv_pcts[4];
    int unsigned                  roll;
    logic [nrgold_pkg::IDX_W-1:0] block_index;
    logic [nrgold_pkg::LEN_W-1:0] seq_length;
    send_pcts = '{0, 85, 0, 29};
    recv_pcts = '{0, 0, 85, 29};
    for (int p = 0; p < 4; p++) begin
      load_seed((p == 0) ? nrgold_pkg::lfsr_t'(0) :
                (p == 3) ? nrgold_pkg::lfsr_t'(1) : nrgold_pkg::lfsr_t'($urandom));
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      for (int k = 0; k < 25; k++) begin
        // hold off once until the block has delivered everything
        if (p == 1 && k == 12) begin
          idle_sender();
          wait_drained();
        end
        roll        = $urandom_range(99);
        block_index = nrgold_pkg::IDX_W'($urandom_range(255));
        // mostly short requests so that large offsets stay affordable
        if (roll < 3) begin
          seq_length = '0;
        end else if (roll < 80) begin
          seq_length = nrgold_pkg::LEN_W'($urandom_range(64, 1));
        end else if (roll < 95) begin
          seq_length = nrgold_pkg::LEN_W'($urandom_range(200, 65));
        end else begin
          block_index = nrgold_pkg::IDX_W'($urandom_range(3));
          seq_length  = nrgold_pkg::LEN_W'($urandom_range(4095, 201));
        end
        send_request(block_index, seq_length);
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_seed();
    test_field_extremes();
    test_random_traffic();
    idle_sender();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #200_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== nr_gold_sequence_generator_unit.f =====
src/nrgold_pkg.sv
src/nr_gold_sequence_generator_unit.sv
dv/nr_gold_sequence_generator_unit_tb.sv
